// ===== design/asc_pkg.sv =====
package asc_pkg;

	// Width of the value as it arrives on the input channel
	localparam int IN_BITS = 16;
	// Bits of the value that take part in the classification
	localparam int VALUE_BITS = 16;
	localparam int N_BITS = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
	// Trial divisor runs up to the square root plus one
	localparam int D_BITS = (N_BITS + 1) / 2 + 1;
	localparam int SQ_BITS = 2 * D_BITS;
	// Proper divisor sum stays below eight times the value
	localparam int SUM_BITS = N_BITS + 3;
	localparam int OUT_SUM_BITS = 18;
	localparam int CMP_BITS = (SUM_BITS > OUT_SUM_BITS) ? SUM_BITS : OUT_SUM_BITS;
	localparam int CNT_BITS = 16;
	localparam int DIV_CNT_BITS = $clog2(N_BITS + 1);

	typedef struct packed {
		logic done;
		logic zero_rem;
		logic [N_BITS-1:0] quo;
	} asc_div_res_t;

	typedef struct packed {
		logic perfect;
		logic almost;
		logic deficient;
		logic abundant;
	} asc_class_t;

	typedef struct packed {
		logic [CNT_BITS-1:0] perfect;
		logic [CNT_BITS-1:0] almost;
		logic [CNT_BITS-1:0] deficient;
		logic [CNT_BITS-1:0] abundant;
	} asc_counts_t;

endpackage

// ===== design/asc_if.sv =====
interface asc_item_if;
	logic valid;
	logic ready;
	logic [asc_pkg::IN_BITS-1:0] value;
	logic last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface asc_result_if;
	logic valid;
	logic ready;
	logic [asc_pkg::OUT_SUM_BITS-1:0] divisor_sum;
	logic is_perfect;
	logic is_almost_perfect;
	logic is_deficient;
	logic is_abundant;
	logic [asc_pkg::CNT_BITS-1:0] perfect_count;
	logic [asc_pkg::CNT_BITS-1:0] almost_count;
	logic [asc_pkg::CNT_BITS-1:0] deficient_count;
	logic [asc_pkg::CNT_BITS-1:0] abundant_count;
	logic set_done;

	modport source (
		output valid, output divisor_sum, output is_perfect, output is_almost_perfect,
		output is_deficient, output is_abundant, output perfect_count, output almost_count,
		output deficient_count, output abundant_count, output set_done, input ready
	);
	modport sink (
		input valid, input divisor_sum, input is_perfect, input is_almost_perfect,
		input is_deficient, input is_abundant, input perfect_count, input almost_count,
		input deficient_count, input abundant_count, input set_done, output ready
	);
endinterface

// ===== design/asc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module asc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [asc_pkg::N_BITS-1:0]   dividend,
	input  logic [asc_pkg::D_BITS-1:0]   divisor,
	output asc_pkg::asc_div_res_t        res
);

	logic                              busy_q;
	logic                              done_q;
	logic [asc_pkg::DIV_CNT_BITS-1:0]  cnt_q;
	logic [asc_pkg::D_BITS-1:0]        rem_q;
	logic [asc_pkg::N_BITS-1:0]        quo_q;
	logic [asc_pkg::D_BITS-1:0]        dvs_q;
	logic [asc_pkg::D_BITS:0]          shifted;
	logic [asc_pkg::D_BITS:0]          diff;
	logic                              fits;

	assign shifted = {rem_q, quo_q[asc_pkg::N_BITS-1]};
	assign fits    = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= asc_pkg::DIV_CNT_BITS'(asc_pkg::N_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - asc_pkg::DIV_CNT_BITS'(1);
				if (cnt_q == asc_pkg::DIV_CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in one dividend bit, subtract where the divisor fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= diff[asc_pkg::D_BITS-1:0];
			end else begin
				rem_q <= shifted[asc_pkg::D_BITS-1:0];
			end
			quo_q <= {quo_q[asc_pkg::N_BITS-2:0], fits};
		end
	end

	assign res.done     = done_q;
	assign res.zero_rem = (rem_q == '0);
	assign res.quo      = quo_q;

endmodule

// ===== design/asc_tally.sv =====
// Saturating class counts for the current set.
module asc_tally (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  commit,
	input  logic                  last,
	input  asc_pkg::asc_class_t   flags,
	output asc_pkg::asc_counts_t  counts_next
);

	asc_pkg::asc_counts_t counts_q;

	function automatic logic [asc_pkg::CNT_BITS-1:0] sat_inc(
		input logic [asc_pkg::CNT_BITS-1:0] c,
		input logic                         hit
	);
		if (!hit || c == '1) begin
			return c;
		end
		return c + asc_pkg::CNT_BITS'(1);
	endfunction

	always_comb begin
		counts_next.perfect   = sat_inc(counts_q.perfect, flags.perfect);
		counts_next.almost    = sat_inc(counts_q.almost, flags.almost);
		counts_next.deficient = sat_inc(counts_q.deficient, flags.deficient);
		counts_next.abundant  = sat_inc(counts_q.abundant, flags.abundant);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_q <= '0;
		end else if (commit) begin
			// drop the counts once the set is closed
			counts_q <= last ? '0 : counts_next;
		end
	end

endmodule

// ===== design/aliquot_sum_classifier_top.sv =====
// Aliquot sum classifier. Each request on item carries a value; the block sums its proper
// divisors by trial division, pairing each divisor d with its cofactor value/d for d from 2 while
// d*d <= value, and returns one result request with the sum (saturated to 18 bits), the perfect,
// almost perfect, deficient and abundant flags, and the four running class counts of the set
// including this value. Counts saturate at 65535 and clear after a result whose set_done is high.
// The value 1 is never classified and 0 falls into no class. One shared restoring divider does
// all the trial divisions, one quotient bit per cycle, and the classify step waits until the
// output register is free before it hands its result over.
// item.ready is high only while no value is in work; a finished result waits in the output
// register, and the next value may be taken while it waits.
module aliquot_sum_classifier_top (
	input  logic                clk,
	input  logic                arst_n,
	asc_item_if.sink            item,
	asc_result_if.source        result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TEST,
		ST_WAIT,
		ST_CLASS
	} state_t;

	state_t                             state_q;
	logic [asc_pkg::N_BITS-1:0]         n_q;
	logic                               last_q;
	logic [asc_pkg::D_BITS-1:0]         d_q;
	logic [asc_pkg::SQ_BITS-1:0]        sq_q;
	logic [asc_pkg::SUM_BITS-1:0]       sum_q;

	logic                               out_valid_q;
	logic [asc_pkg::OUT_SUM_BITS-1:0]   out_sum_q;
	asc_pkg::asc_class_t                out_flags_q;
	asc_pkg::asc_counts_t               out_counts_q;
	logic                               out_last_q;

	logic                               div_start;
	asc_pkg::asc_div_res_t              div_res;
	logic                               trial_over;
	logic                               commit;
	asc_pkg::asc_class_t                flags;
	asc_pkg::asc_counts_t               counts_next;
	logic [asc_pkg::SUM_BITS-1:0]       n_ext;
	logic [asc_pkg::SUM_BITS-1:0]       cofactor;
	logic [asc_pkg::CMP_BITS-1:0]       sum_wide;
	logic [asc_pkg::OUT_SUM_BITS-1:0]   sum_sat;

	// Stop trials once d*d passes the value
	assign trial_over = sq_q > asc_pkg::SQ_BITS'(n_q);
	assign div_start  = (state_q == ST_TEST) && !trial_over;

	asc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (n_q),
		.divisor  (d_q),
		.res      (div_res)
	);

	// A square divisor contributes once
	assign cofactor = (div_res.quo != asc_pkg::N_BITS'(d_q))
		? asc_pkg::SUM_BITS'(div_res.quo) : '0;

	// Classify; values 1 and 0 stay out of every class (the sum for 0 is 0)
	always_comb begin
		n_ext           = asc_pkg::SUM_BITS'(n_q);
		flags.perfect   = (n_q > asc_pkg::N_BITS'(1)) && (sum_q == n_ext);
		flags.almost    = (n_q > asc_pkg::N_BITS'(1)) && (sum_q == n_ext - asc_pkg::SUM_BITS'(1));
		flags.deficient = (n_q != asc_pkg::N_BITS'(1)) && (sum_q < n_ext);
		flags.abundant  = (n_q != asc_pkg::N_BITS'(1)) && (sum_q > n_ext);
	end

	assign sum_wide = asc_pkg::CMP_BITS'(sum_q);
	assign sum_sat  = (sum_wide > asc_pkg::CMP_BITS'({asc_pkg::OUT_SUM_BITS{1'b1}}))
		? '1 : sum_wide[asc_pkg::OUT_SUM_BITS-1:0];

	// Hand the result over only once the output register is free
	assign commit = (state_q == ST_CLASS) && (!out_valid_q || result.ready);

	asc_tally u_tally (
		.clk         (clk),
		.arst_n      (arst_n),
		.commit      (commit),
		.last        (last_q),
		.flags       (flags),
		.counts_next (counts_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			n_q          <= '0;
			last_q       <= 1'b0;
			d_q          <= '0;
			sq_q         <= '0;
			sum_q        <= '0;
			out_valid_q  <= 1'b0;
			out_sum_q    <= '0;
			out_flags_q  <= '0;
			out_counts_q <= '0;
			out_last_q   <= 1'b0;
		end else begin
			// load a new result, or drop the old one once it is taken
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						n_q    <= item.value[asc_pkg::N_BITS-1:0];
						last_q <= item.last;
						d_q    <= asc_pkg::D_BITS'(2);
						sq_q   <= asc_pkg::SQ_BITS'(4);
						// 1 divides every value above 1
						sum_q  <= (item.value[asc_pkg::N_BITS-1:0] > asc_pkg::N_BITS'(1))
							? asc_pkg::SUM_BITS'(1) : '0;
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if (trial_over) begin
						state_q <= ST_CLASS;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (div_res.done) begin
						if (div_res.zero_rem) begin
							sum_q <= sum_q + asc_pkg::SUM_BITS'(d_q) + cofactor;
						end
						// advance d and keep d*d in step: (d+1)^2 = d^2 + 2d + 1
						d_q     <= d_q + asc_pkg::D_BITS'(1);
						sq_q    <= sq_q + asc_pkg::SQ_BITS'({d_q, 1'b1});
						state_q <= ST_TEST;
					end
				end
				ST_CLASS: begin
					if (commit) begin
						out_sum_q    <= sum_sat;
						out_flags_q  <= flags;
						out_counts_q <= counts_next;
						out_last_q   <= last_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item.ready = (state_q == ST_IDLE);

	assign result.valid             = out_valid_q;
	assign result.divisor_sum       = out_sum_q;
	assign result.is_perfect        = out_flags_q.perfect;
	assign result.is_almost_perfect = out_flags_q.almost;
	assign result.is_deficient      = out_flags_q.deficient;
	assign result.is_abundant       = out_flags_q.abundant;
	assign result.perfect_count     = out_counts_q.perfect;
	assign result.almost_count      = out_counts_q.almost;
	assign result.deficient_count   = out_counts_q.deficient;
	assign result.abundant_count    = out_counts_q.abundant;
	assign result.set_done          = out_last_q;

endmodule

// ===== design/asc_checker.sv =====
module asc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           item_valid,
	input logic                           item_ready,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic [asc_pkg::OUT_SUM_BITS-1:0] res_sum,
	input logic                           res_perfect,
	input logic                           res_almost,
	input logic                           res_deficient,
	input logic                           res_abundant,
	input logic [asc_pkg::CNT_BITS-1:0]   res_perfect_count,
	input logic [asc_pkg::CNT_BITS-1:0]   res_abundant_count
);

	// Block is busy on the cycle after it takes a request
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item.ready high straight after a request was taken");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_sum))
		else $error("stalled result dropped or changed");

	a_abundant_alone: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_abundant |-> !res_deficient && !res_perfect && !res_almost)
		else $error("abundant result carries another class");

	a_perfect_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_perfect |-> res_perfect_count != '0)
		else $error("perfect result with zero perfect count");

	a_abundant_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_abundant |-> res_abundant_count != '0)
		else $error("abundant result with zero abundant count");

endmodule

bind aliquot_sum_classifier_top asc_checker u_asc_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.item_valid         (item.valid),
	.item_ready         (item.ready),
	.res_valid          (result.valid),
	.res_ready          (result.ready),
	.res_sum            (result.divisor_sum),
	.res_perfect        (result.is_perfect),
	.res_almost         (result.is_almost_perfect),
	.res_deficient      (result.is_deficient),
	.res_abundant       (result.is_abundant),
	.res_perfect_count  (result.perfect_count),
	.res_abundant_count (result.abundant_count)
);
